/* rtl/uart_rx_deframe_fifo_unit_defines.svh */
// Assertion macros for the RTL files of the receive deframer.
// Each macro names the clock and the active-low reset explicitly.
`ifndef UART_RX_DEFRAME_FIFO_UNIT_DEFINES_SVH
`define UART_RX_DEFRAME_FIFO_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication: when ante holds, cons holds at that edge.
`define URDF_ASSERT_HOLD(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("urdf assertion failed: same-cycle implication");

// Next-cycle implication: when ante holds, cons holds at the following edge.
`define URDF_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("urdf assertion failed: next-cycle implication");

`else

`define URDF_ASSERT_HOLD(label, clk, rstn, ante, cons)
`define URDF_ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

/* rtl/urdf_pkg.sv */
`default_nettype none

package urdf_pkg;

    // Request actions
    localparam logic [1:0] ACT_SAMPLE = 2'd0;
    localparam logic [1:0] ACT_READ   = 2'd1;
    localparam logic [1:0] ACT_CLEAR  = 2'd2;

    // Parity selector codes
    localparam logic [1:0] PAR_NONE = 2'd0;
    localparam logic [1:0] PAR_EVEN = 2'd1;
    localparam logic [1:0] PAR_ODD  = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_DATA_BITS   = 2'd0;
    localparam logic [1:0] CFG_PARITY_MODE = 2'd1;
    localparam logic [1:0] CFG_STOP_BITS   = 2'd2;

    // Field widths
    localparam int unsigned ACTION_W = 2;
    localparam int unsigned RAW_W    = 32;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 4;

    // Frame alignment: sample word is shifted right by FRAME_TOP minus half-bit count
    localparam int unsigned FRAME_TOP = 33;

    // Data width limits and the widest frame payload (data plus parity bit)
    localparam logic [3:0] DATA_BITS_MIN = 4'd5;
    localparam logic [3:0] DATA_BITS_MAX = 4'd8;
    localparam int unsigned FRAME_BITS = 9;

    // Reset values of the configuration registers
    localparam logic [3:0] DATA_BITS_RST   = 4'd8;
    localparam logic [1:0] PARITY_MODE_RST = PAR_NONE;
    localparam logic [1:0] STOP_BITS_RST   = 2'd1;

endpackage

`default_nettype wire

/* rtl/uart_rx_deframe_fifo_unit.sv */
`default_nettype none

// UART receive deframer with parity check and a byte queue of BUFFERED_BYTES
// entries (the ring has one slot more, always kept free). Each request carries
// an action: a sample word of twice-oversampled line samples (MSB aligned) is
// decoded, parity checked and pushed; a read pops the head byte; a status read
// returns the sticky overflow flag and clears it. Every request gives exactly
// one result with the fill count and the head byte. Throughput is one request
// per cycle while the result is not stalled. A request is held in the input
// register, where decode, pointer update and the ring's single write and
// single registered read take place, and then moves to the result register,
// which presents its result. A stalled result holds the input register, and
// once that is also occupied the input channel stalls. The ring memory is not
// cleared after reset; only written entries are ever reported.
// Configuration writes are taken in any cycle and must only be issued while no
// request is in flight.
`include "uart_rx_deframe_fifo_unit_defines.svh"

module uart_rx_deframe_fifo_unit #(
    parameter int unsigned BUFFERED_BYTES = 32
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,

    input  wire logic                                   s_valid,
    output logic                                        s_ready,
    input  wire logic [urdf_pkg::ACTION_W-1:0]          s_action,
    input  wire logic [urdf_pkg::RAW_W-1:0]             s_raw_samples,

    output logic                                        m_valid,
    input  wire logic                                   m_ready,
    output logic [urdf_pkg::BYTE_W-1:0]                 m_byte_value,
    output logic                                        m_byte_valid,
    output logic                                        m_overflow_status,
    output logic [$clog2(BUFFERED_BYTES+1)-1:0]         m_fill_count,
    output logic                                        m_parity_fault,
    output logic                                        m_dropped_full,

    input  wire logic                                   cfg_valid,
    output logic                                        cfg_ready,
    input  wire logic [urdf_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  wire logic [urdf_pkg::CFG_DATA_W-1:0]        cfg_data
);

    localparam int unsigned SLOTS  = BUFFERED_BYTES + 1;
    localparam int unsigned PTR_W  = $clog2(SLOTS);
    localparam int unsigned FILL_W = $clog2(BUFFERED_BYTES + 1);
    localparam logic [PTR_W-1:0]  LAST_SLOT = PTR_W'(SLOTS - 1);
    localparam logic [FILL_W-1:0] FULL_FILL = FILL_W'(BUFFERED_BYTES);

    // Configuration registers
    logic [3:0] data_bits_reg;
    logic [1:0] parity_mode_reg;
    logic [1:0] stop_bits_reg;

    // Input register
    logic                               a_valid_reg;
    logic [urdf_pkg::ACTION_W-1:0]      a_action_reg;
    logic [urdf_pkg::RAW_W-1:0]         a_raw_reg;

    // Ring state
    logic [urdf_pkg::BYTE_W-1:0] ring_mem [0:SLOTS-1];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FILL_W-1:0]  count_reg, count_next;
    logic               ovf_reg, ovf_next;

    // Result register
    logic                           m_valid_reg;
    logic                           byte_valid_reg;
    logic                           ovf_out_reg;
    logic [FILL_W-1:0]              fill_reg;
    logic                           pfault_reg;
    logic                           dfull_reg;
    logic                           bypass_reg;
    logic [urdf_pkg::BYTE_W-1:0]    bypass_byte_reg;
    logic [urdf_pkg::BYTE_W-1:0]    mem_rd_reg;

    // Step decode
    logic                           advance;
    logic [3:0]                     nb_eff;
    logic [1:0]                     st_eff;
    logic                           par_on;
    logic [1:0]                     par_eff;
    logic [5:0]                     units;
    logic [5:0]                     half_bits;
    logic [5:0]                     shamt;
    logic [urdf_pkg::RAW_W-1:0]     dec;
    logic [urdf_pkg::FRAME_BITS-1:0] frame_v;
    logic [urdf_pkg::BYTE_W-1:0]    data_byte;
    logic                           par_calc;
    logic                           par_rx;
    logic                           is_sample;
    logic                           pfault;
    logic                           full;
    logic                           push;
    logic                           dfull;
    logic                           pop;
    logic                           bypass;
    logic                           byte_valid;
    logic                           ovf_status;

    assign cfg_ready = 1'b1;
    assign advance   = a_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready   = !a_valid_reg || advance;

    // Write configuration registers; unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            data_bits_reg   <= urdf_pkg::DATA_BITS_RST;
            parity_mode_reg <= urdf_pkg::PARITY_MODE_RST;
            stop_bits_reg   <= urdf_pkg::STOP_BITS_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                urdf_pkg::CFG_DATA_BITS:   data_bits_reg   <= cfg_data;
                urdf_pkg::CFG_PARITY_MODE: parity_mode_reg <= cfg_data[1:0];
                urdf_pkg::CFG_STOP_BITS:   stop_bits_reg   <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // Hold the accepted request until it moves to the result stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            a_valid_reg <= 1'b1;
        end else if (advance) begin
            a_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            a_action_reg <= s_action;
            a_raw_reg    <= s_raw_samples;
        end
    end

    // Clamp the configuration to its legal range
    always_comb begin
        if (data_bits_reg < urdf_pkg::DATA_BITS_MIN) begin
            nb_eff = urdf_pkg::DATA_BITS_MIN;
        end else if (data_bits_reg > urdf_pkg::DATA_BITS_MAX) begin
            nb_eff = urdf_pkg::DATA_BITS_MAX;
        end else begin
            nb_eff = data_bits_reg;
        end
        st_eff  = (stop_bits_reg >= 2'd2) ? 2'd2 : 2'd1;
        par_eff = (parity_mode_reg == urdf_pkg::PAR_EVEN ||
                   parity_mode_reg == urdf_pkg::PAR_ODD) ? parity_mode_reg
                                                          : urdf_pkg::PAR_NONE;
        par_on  = (par_eff != urdf_pkg::PAR_NONE);
    end

    // Align the sample word and pick every second sample
    always_comb begin
        units     = 6'(nb_eff) + 6'(st_eff) + 6'(par_on) + 6'd1;
        half_bits = {units[4:0], 1'b0} - 6'd1;
        shamt     = 6'(urdf_pkg::FRAME_TOP) - half_bits;
        dec       = a_raw_reg >> shamt;
        for (int b = 0; b < int'(urdf_pkg::FRAME_BITS); b++) begin
            frame_v[b] = dec[2*b];
        end
        par_calc = 1'b0;
        for (int b = 0; b < int'(urdf_pkg::BYTE_W); b++) begin
            data_byte[b] = frame_v[b] && (b < int'(nb_eff));
            par_calc     = par_calc ^ data_byte[b];
        end
        par_rx = frame_v[nb_eff];
    end

    // Decide push, drop and pop, and advance the ring state
    always_comb begin
        is_sample = (a_action_reg == urdf_pkg::ACT_SAMPLE);
        pfault    = is_sample &&
                    ((par_eff == urdf_pkg::PAR_EVEN && par_calc != par_rx) ||
                     (par_eff == urdf_pkg::PAR_ODD  && par_calc == par_rx));
        full      = (count_reg == FULL_FILL);
        push      = is_sample && !pfault && !full;
        dfull     = is_sample && !pfault && full;
        pop       = (a_action_reg == urdf_pkg::ACT_READ) && (count_reg != '0);
        bypass    = push && (count_reg == '0);

        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + 1'b1;
            count_next  = count_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + 1'b1;
            count_next  = count_reg - 1'b1;
        end

        ovf_status = ovf_reg || dfull;
        ovf_next   = (a_action_reg == urdf_pkg::ACT_CLEAR) ? 1'b0 : ovf_status;
        byte_valid = pop || (count_next != '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            ovf_reg    <= 1'b0;
        end else if (advance) begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
            ovf_reg    <= ovf_next;
        end
    end

    // Ring memory: one write, one registered read at the current head
    always_ff @(posedge aclk) begin
        if (advance) begin
            if (push) begin
                ring_mem[wr_ptr_reg] <= data_byte;
            end
            mem_rd_reg <= ring_mem[rd_ptr_reg];
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            byte_valid_reg  <= byte_valid;
            ovf_out_reg     <= ovf_status;
            fill_reg        <= count_next;
            pfault_reg      <= pfault;
            dfull_reg       <= dfull;
            bypass_reg      <= bypass;
            bypass_byte_reg <= data_byte;
        end
    end

    // Forward a byte pushed into an empty ring, zero when nothing is queued
    always_comb begin
        if (!byte_valid_reg) begin
            m_byte_value = '0;
        end else if (bypass_reg) begin
            m_byte_value = bypass_byte_reg;
        end else begin
            m_byte_value = mem_rd_reg;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_byte_valid      = byte_valid_reg;
    assign m_overflow_status = ovf_out_reg;
    assign m_fill_count      = fill_reg;
    assign m_parity_fault    = pfault_reg;
    assign m_dropped_full    = dfull_reg;

    // Checks
    `URDF_ASSERT_HOLD(a_fill_bound, aclk, aresetn, 1'b1, count_reg <= FULL_FILL)
    `URDF_ASSERT_HOLD(a_empty_ptrs, aclk, aresetn, count_reg == '0, wr_ptr_reg == rd_ptr_reg)
    `URDF_ASSERT_HOLD(a_drop_sets_ovf, aclk, aresetn, m_valid_reg && dfull_reg, ovf_out_reg)
    `URDF_ASSERT_HOLD(a_one_drop_cause, aclk, aresetn, m_valid_reg, !(pfault_reg && dfull_reg))
    `URDF_ASSERT_NEXT(a_pop_dec, aclk, aresetn, advance && pop, count_reg + 1'b1 == $past(count_reg))

endmodule

`default_nettype wire
